// File: src/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication check, held off while reset is asserted
`define CHK_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("check failed: same-cycle implication");

// Next-cycle implication check, held off while reset is asserted
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("check failed: next-cycle implication");

`endif

// File: src/biq_pkg.sv
`default_nettype none

package biq_pkg;

	// Datapath widths
	localparam int SAMPLE_WIDTH   = 24;
	localparam int COEF_WIDTH     = 32;
	localparam int COEF_FRAC_BITS = 26;
	localparam int OUT_WIDTH      = SAMPLE_WIDTH + 1;
	localparam int PROD_WIDTH     = COEF_WIDTH + OUT_WIDTH;
	// Five products plus sign growth of the sum
	localparam int ACC_WIDTH      = PROD_WIDTH + 3;
	localparam int ONE_SHIFT      = SAMPLE_WIDTH - 1 + COEF_FRAC_BITS;

	// Configuration register map
	localparam int NUM_COEFS      = 5;
	localparam int CFG_ADDR_WIDTH = $clog2(NUM_COEFS);

	typedef enum logic [CFG_ADDR_WIDTH-1:0] {
		REG_B0,
		REG_B1,
		REG_B2,
		REG_A1,
		REG_A2
	} cfg_reg_t;

	// Coefficient reset values
	localparam logic signed [COEF_WIDTH-1:0] COEF_ONE  = COEF_WIDTH'(1) << COEF_FRAC_BITS;
	localparam logic signed [COEF_WIDTH-1:0] COEF_ZERO = '0;

	// Accumulator constants: +1.0 in the exact product scale and half an output LSB
	localparam logic signed [ACC_WIDTH-1:0] ACC_ONE  = ACC_WIDTH'(1) << ONE_SHIFT;
	localparam logic signed [ACC_WIDTH-1:0] ACC_HALF = ACC_WIDTH'(1) << (COEF_FRAC_BITS - 1);

	// Output range limits in Q2.23
	localparam logic signed [OUT_WIDTH-1:0] OUT_MAX = OUT_WIDTH'(1) << (SAMPLE_WIDTH - 1);
	localparam logic signed [OUT_WIDTH-1:0] OUT_MIN = -OUT_MAX;

	typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
	typedef logic signed [OUT_WIDTH-1:0]    out_sample_t;
	typedef logic signed [COEF_WIDTH-1:0]   coef_t;
	typedef logic signed [ACC_WIDTH-1:0]    acc_t;

	typedef struct packed {
		coef_t b0;
		coef_t b1;
		coef_t b2;
		coef_t a1;
		coef_t a2;
	} coef_set_t;

	typedef struct packed {
		sample_t     x1;
		sample_t     x2;
		out_sample_t y1;
		out_sample_t y2;
	} hist_t;

endpackage

`default_nettype wire

// File: src/biq_in_if.sv
`default_nettype none

interface biq_in_if;
	import biq_pkg::*;

	logic    valid;
	logic    ready;
	sample_t sample_in;
	logic    restart;

	modport source (output valid, output sample_in, output restart, input ready);
	modport sink (input valid, input sample_in, input restart, output ready);

endinterface

`default_nettype wire

// File: src/biq_out_if.sv
`default_nettype none

interface biq_out_if;
	import biq_pkg::*;

	logic        valid;
	logic        ready;
	out_sample_t sample_out;
	logic        overflow;

	modport source (output valid, output sample_out, output overflow, input ready);
	modport sink (input valid, input sample_out, input overflow, output ready);

endinterface

`default_nettype wire

// File: src/biq_coef_regs.sv
`default_nettype none

module biq_coef_regs (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [biq_pkg::CFG_ADDR_WIDTH-1:0] cfg_addr,
	input  wire logic [biq_pkg::COEF_WIDTH-1:0]   cfg_data,
	output biq_pkg::coef_set_t                    coefs
);
	import biq_pkg::*;

	coef_set_t coefs_q;

	// Decode the write index; writes past the last register are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coefs_q.b0 <= COEF_ONE;
			coefs_q.b1 <= COEF_ZERO;
			coefs_q.b2 <= COEF_ZERO;
			coefs_q.a1 <= COEF_ZERO;
			coefs_q.a2 <= COEF_ZERO;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_B0: coefs_q.b0 <= cfg_data;
				REG_B1: coefs_q.b1 <= cfg_data;
				REG_B2: coefs_q.b2 <= cfg_data;
				REG_A1: coefs_q.a1 <= cfg_data;
				REG_A2: coefs_q.a2 <= cfg_data;
				default: ;
			endcase
		end
	end

	assign coefs = coefs_q;

endmodule

`default_nettype wire

// File: src/biq_mac.sv
`default_nettype none

module biq_mac (
	input  wire biq_pkg::sample_t     sample,
	input  wire biq_pkg::hist_t       hist,
	input  wire biq_pkg::coef_set_t   coefs,
	output biq_pkg::out_sample_t      y,
	output logic                      ovf
);
	import biq_pkg::*;

	logic signed [PROD_WIDTH-1:0] p_b0;
	logic signed [PROD_WIDTH-1:0] p_b1;
	logic signed [PROD_WIDTH-1:0] p_b2;
	logic signed [PROD_WIDTH-1:0] p_a1;
	logic signed [PROD_WIDTH-1:0] p_a2;
	acc_t                         acc;
	acc_t                         rounded;

	// Five independent signed products, exact
	assign p_b0 = coefs.b0 * sample;
	assign p_b1 = coefs.b1 * hist.x1;
	assign p_b2 = coefs.b2 * hist.x2;
	assign p_a1 = coefs.a1 * hist.y1;
	assign p_a2 = coefs.a2 * hist.y2;

	// Exact sum; feedback terms are subtracted
	assign acc = ACC_WIDTH'(p_b0) + ACC_WIDTH'(p_b1) + ACC_WIDTH'(p_b2)
		- ACC_WIDTH'(p_a1) - ACC_WIDTH'(p_a2);

	// Overflow when the exact sum lies strictly outside -1.0..+1.0
	assign ovf = (acc > ACC_ONE) || (acc < -ACC_ONE);

	// Round half up to Q2.23, zero on overflow
	assign rounded = (acc + ACC_HALF) >>> COEF_FRAC_BITS;
	assign y       = ovf ? '0 : rounded[OUT_WIDTH-1:0];

endmodule

`default_nettype wire

// File: src/biquad_iir_with_overflow_reset_core.sv
// Direct-form-I biquad on signed Q1.23 samples with Q6.26 coefficients b0, b1, b2, a1, a2
// (register indexes 0 to 4, b0 resets to 1.0, the rest to zero). It takes one sample per
// clock while the result side is ready: the five products, their exact sum, the overflow
// test and the rounding run in one registered pass from the input register to the result
// register; that pass, which closes the loop through the output history, sets the rate.
// Results leave the result register. A sum beyond magnitude 1.0 gives a zero sample with
// the overflow flag set and clears the newest output history; restart clears all history
// before its own sample. Write the coefficients only while no sample is in flight.
`default_nettype none

`include "assert_macros.svh"

module biquad_iir_with_overflow_reset_core (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	biq_in_if.sink                                  sample_ch,
	biq_out_if.source                               result_ch,
	input  wire logic                               cfg_we,
	input  wire logic [biq_pkg::CFG_ADDR_WIDTH-1:0] cfg_addr,
	input  wire logic [biq_pkg::COEF_WIDTH-1:0]     cfg_data
);
	import biq_pkg::*;

	coef_set_t   coefs;
	logic        valid_s1;
	sample_t     sample_s1;
	logic        restart_s1;
	logic        out_valid_q;
	out_sample_t out_sample_q;
	logic        out_ovf_q;
	hist_t       hist_q;
	hist_t       hist_eff;
	hist_t       hist_next;
	out_sample_t y;
	logic        ovf;
	logic        advance;

	biq_coef_regs u_coef_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_data (cfg_data),
		.coefs    (coefs)
	);

	// Move the sample into the result register when that register is free or drains
	assign advance         = valid_s1 && (!out_valid_q || result_ch.ready);
	assign sample_ch.ready = !valid_s1 || advance;

	// Restart drops all history for this sample
	assign hist_eff = restart_s1 ? '0 : hist_q;

	biq_mac u_mac (
		.sample (sample_s1),
		.hist   (hist_eff),
		.coefs  (coefs),
		.y      (y),
		.ovf    (ovf)
	);

	// Shift the history; an overflow leaves a zero as newest output
	always_comb begin
		hist_next.x1 = sample_s1;
		hist_next.x2 = hist_eff.x1;
		hist_next.y1 = y;
		hist_next.y2 = hist_eff.y1;
	end

	// Input stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample_ch.ready) begin
			valid_s1 <= sample_ch.valid;
		end
	end

	// Input stage payload
	always_ff @(posedge clk) begin
		if (sample_ch.ready && sample_ch.valid) begin
			sample_s1  <= sample_ch.sample_in;
			restart_s1 <= sample_ch.restart;
		end
	end

	// Result register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (result_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result register payload
	always_ff @(posedge clk) begin
		if (advance) begin
			out_sample_q <= y;
			out_ovf_q    <= ovf;
		end
	end

	// Filter history, advanced with each transfer into the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_q <= '0;
		end else if (advance) begin
			hist_q <= hist_next;
		end
	end

	assign result_ch.valid      = out_valid_q;
	assign result_ch.sample_out = out_sample_q;
	assign result_ch.overflow   = out_ovf_q;

	// The waiting result is always the newest output history
	`CHK_IMPL(a_hist_tracks_result, clk, arst_n, out_valid_q, hist_q.y1 == out_sample_q)

	// A result without overflow stays within -1.0..+1.0
	`CHK_IMPL(a_result_in_range, clk, arst_n, out_valid_q && !out_ovf_q,
		(out_sample_q <= OUT_MAX) && (out_sample_q >= OUT_MIN))

	// A stalled input stage keeps its sample
	`CHK_NEXT(a_stall_holds, clk, arst_n, valid_s1 && !advance,
		valid_s1 && $stable(sample_s1) && $stable(restart_s1))

	// Restart leaves nothing older than its own sample in the history
	`CHK_NEXT(a_restart_clears, clk, arst_n, advance && restart_s1,
		(hist_q.x2 == '0) && (hist_q.y2 == '0))

endmodule

`default_nettype wire

// File: tb/tb_biquad_iir_with_overflow_reset_core.sv
module tb_biquad_iir_with_overflow_reset_core;
	import biq_pkg::*;

	typedef struct packed {
		out_sample_t sample_out;
		logic        overflow;
	} filt_result_t;

	localparam sample_t SMP_MAX      = 24'sh7FFFFF;
	localparam sample_t SMP_MIN      = 24'sh800000;
	localparam coef_t   COEF_MAX     = 32'sh7FFFFFFF;
	localparam coef_t   COEF_MIN     = 32'sh80000000;
	localparam coef_t   COEF_NEG_ONE = -COEF_ONE;
	localparam coef_t   COEF_HALF    = COEF_ONE >>> 1;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_ADDR_WIDTH-1:0] cfg_addr;
	logic [COEF_WIDTH-1:0] cfg_data;
	logic rx_ready = 1'b0;

	biq_in_if  sample_if ();
	biq_out_if result_if ();

	assign result_if.ready = rx_ready;

	biquad_iir_with_overflow_reset_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.sample_ch (sample_if),
		.result_ch (result_if),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_data  (cfg_data)
	);

	// Filter shadow state: coefficients, history and outputs still owed by the block
	coef_set_t    filt_coef;
	hist_t        filt_hist;
	filt_result_t pending_outputs[$];
	int           mismatches = 0;
	int           outputs_seen = 0;
	int           tx_gap_max = 7;
	int           rx_stall_max = 7;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("FAILURE");
		$finish;
	end

	// Run one sample through the filter shadow and return what the block must produce
	function automatic filt_result_t filter_step(sample_t x, logic restart);
		longint acc;
		longint one;
		longint half;
		filt_result_t res;
		if (restart)
			filt_hist = '0;
		acc = longint'($signed(filt_coef.b0)) * longint'(x)
			+ longint'($signed(filt_coef.b1)) * longint'($signed(filt_hist.x1))
			+ longint'($signed(filt_coef.b2)) * longint'($signed(filt_hist.x2))
			- longint'($signed(filt_coef.a1)) * longint'($signed(filt_hist.y1))
			- longint'($signed(filt_coef.a2)) * longint'($signed(filt_hist.y2));
		one  = longint'(1) << ONE_SHIFT;
		half = longint'(1) << (COEF_FRAC_BITS - 1);
		// Test overflow on the exact sum; an exact +/-1.0 still passes
		res.overflow = (acc > one) || (acc < -one);
		res.sample_out = res.overflow ? '0 : out_sample_t'((acc + half) >>> COEF_FRAC_BITS);
		filt_hist.x2 = filt_hist.x1;
		filt_hist.x1 = x;
		filt_hist.y2 = filt_hist.y1;
		filt_hist.y1 = res.sample_out;
		return res;
	endfunction

	task automatic note_mismatch(string what, longint exp_val, longint act_val);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch on %s at %0t: expected %0d, got %0d", what, $realtime,
				exp_val, act_val);
	endtask

	// Compare each output transfer against the oldest owed result
	always @(posedge clk) begin
		filt_result_t want;
		if (arst_n && result_if.valid && result_if.ready) begin
			outputs_seen <= outputs_seen + 1;
			if (pending_outputs.size() == 0) begin
				note_mismatch("unexpected output", 0, result_if.sample_out);
			end else begin
				want = pending_outputs.pop_front();
				if (result_if.sample_out !== want.sample_out)
					note_mismatch("sample_out", want.sample_out, result_if.sample_out);
				if (result_if.overflow !== want.overflow)
					note_mismatch("overflow", want.overflow, result_if.overflow);
			end
		end
	end

	// Hold ready low for a random stall after each output transfer
	always @(negedge clk) begin
		static int stall_left = 0;
		static int seen_mark = 0;
		if (outputs_seen != seen_mark) begin
			seen_mark = outputs_seen;
			stall_left = $urandom_range(0, rx_stall_max);
		end
		if (stall_left > 0) begin
			rx_ready <= 1'b0;
			stall_left--;
		end else begin
			rx_ready <= 1'b1;
		end
	end

	// Offer one sample after a random gap and record its result once transferred
	task automatic send_sample(sample_t x, logic restart);
		int gap;
		gap = $urandom_range(0, tx_gap_max);
		@(negedge clk);
		repeat (gap) begin
			sample_if.valid <= 1'b0;
			@(negedge clk);
		end
		sample_if.valid     <= 1'b1;
		sample_if.sample_in <= x;
		sample_if.restart   <= restart;
		do @(posedge clk); while (!sample_if.ready);
		pending_outputs.push_back(filter_step(x, restart));
	endtask

	// Drop valid and drain every owed result, then let the pipeline settle
	task automatic wait_idle();
		@(negedge clk);
		sample_if.valid <= 1'b0;
		while (pending_outputs.size() != 0)
			@(posedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, coef_t val);
		@(negedge clk);
		cfg_we   <= 1'b1;
		cfg_addr <= idx;
		cfg_data <= val;
		case (idx)
			REG_B0: filt_coef.b0 = val;
			REG_B1: filt_coef.b1 = val;
			REG_B2: filt_coef.b2 = val;
			REG_A1: filt_coef.a1 = val;
			REG_A2: filt_coef.a2 = val;
			default: ;
		endcase
	endtask

	task automatic load_coefs(coef_set_t c);
		write_reg(REG_B0, c.b0);
		write_reg(REG_B1, c.b1);
		write_reg(REG_B2, c.b2);
		write_reg(REG_A1, c.a1);
		write_reg(REG_A2, c.a2);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Reset coefficients pass samples straight through, full scale included
	task automatic test_default_passthrough();
		send_sample('0, 1'b0);
		send_sample(SMP_MAX, 1'b0);
		send_sample(SMP_MIN, 1'b0);
		send_sample(24'sh555555, 1'b0);
		send_sample(24'shAAAAAA, 1'b0);
		wait_idle();
	endtask

	// Exact +1.0, overflow on coefficient extremes, and half-LSB rounding
	task automatic test_limits_and_rounding();
		load_coefs('{COEF_NEG_ONE, COEF_ZERO, COEF_ZERO, COEF_ZERO, COEF_ZERO});
		send_sample(SMP_MIN, 1'b0);
		send_sample(SMP_MAX, 1'b0);
		wait_idle();
		load_coefs('{COEF_MAX, COEF_ZERO, COEF_ZERO, COEF_ZERO, COEF_ZERO});
		send_sample(SMP_MIN, 1'b0);
		send_sample(24'sd1, 1'b0);
		send_sample('0, 1'b0);
		wait_idle();
		load_coefs('{COEF_MIN, COEF_ZERO, COEF_ZERO, COEF_ZERO, COEF_ZERO});
		send_sample(SMP_MAX, 1'b0);
		send_sample(SMP_MIN, 1'b0);
		wait_idle();
		load_coefs('{COEF_HALF, COEF_ZERO, COEF_ZERO, COEF_ZERO, COEF_ZERO});
		send_sample(24'sd3, 1'b0);
		send_sample(-24'sd3, 1'b0);
		wait_idle();
	endtask

	// Overflow zeroes the newest output history while the older one shifts on
	task automatic test_overflow_history();
		load_coefs('{COEF_ONE, COEF_ONE, COEF_ZERO, COEF_ZERO, COEF_HALF});
		send_sample(SMP_MAX, 1'b1);
		send_sample(SMP_MAX, 1'b0);
		send_sample('0, 1'b0);
		send_sample(24'sd5, 1'b1);
		wait_idle();
	endtask

	// Extreme values on every history tap
	task automatic test_coef_extremes();
		load_coefs('{COEF_ZERO, COEF_MAX, COEF_MIN, COEF_MIN, COEF_MAX});
		send_sample(24'sd1, 1'b1);
		send_sample('0, 1'b0);
		send_sample('0, 1'b0);
		send_sample('0, 1'b0);
		wait_idle();
		load_coefs('{COEF_ZERO, COEF_MIN, COEF_MAX, COEF_MAX, COEF_MIN});
		send_sample(-24'sd1, 1'b1);
		send_sample('0, 1'b0);
		wait_idle();
	endtask

	// Random coefficient sets, each followed by a run of random samples
	task automatic test_random_filters(int phases, int per_phase);
		coef_t    v[5];
		int       style;
		int       pick;
		sample_t  x;
		for (int p = 0; p < phases; p++) begin
			style = $urandom_range(0, 2);
			for (int k = 0; k < 5; k++) begin
				case (style)
					// Modest gains, feedback around the stability edge
					0: begin
						if (k < 3)
							v[k] = coef_t'(int'($urandom_range(0, 1 << 25)) - (1 << 24));
						else if (k == 3)
							v[k] = coef_t'(int'($urandom_range(0, 3 << 26)) - (3 << 25));
						else
							v[k] = coef_t'(int'($urandom_range(0, 1 << 26)) - (1 << 25));
					end
					// Full range with frequent extremes
					1: begin
						pick = $urandom_range(0, 7);
						if (pick == 0)
							v[k] = COEF_MAX;
						else if (pick == 1)
							v[k] = COEF_MIN;
						else if (pick == 2)
							v[k] = COEF_ZERO;
						else
							v[k] = coef_t'($urandom);
					end
					// Near unity gain, results hug the limits
					default: begin
						if (k == 0)
							v[k] = COEF_ONE + coef_t'(int'($urandom_range(0, 1 << 21)) - (1 << 20));
						else
							v[k] = coef_t'(int'($urandom_range(0, 1 << 23)) - (1 << 22));
					end
				endcase
			end
			wait_idle();
			load_coefs('{v[0], v[1], v[2], v[3], v[4]});
			case ($urandom_range(0, 3))
				0: begin tx_gap_max = 0; rx_stall_max = 0; end
				1: begin tx_gap_max = 7; rx_stall_max = 0; end
				2: begin tx_gap_max = 0; rx_stall_max = 7; end
				default: begin tx_gap_max = 7; rx_stall_max = 7; end
			endcase
			for (int i = 0; i < per_phase; i++) begin
				pick = $urandom_range(0, 9);
				if (pick == 0)
					x = SMP_MAX;
				else if (pick == 1)
					x = SMP_MIN;
				else if (pick == 2)
					x = sample_t'(int'($urandom_range(0, 510)) - 255);
				else
					x = sample_t'($urandom);
				send_sample(x, $urandom_range(0, 15) == 0);
			end
		end
		wait_idle();
	endtask

	initial begin
		sample_if.valid     = 1'b0;
		sample_if.sample_in = '0;
		sample_if.restart   = 1'b0;
		cfg_we   = 1'b0;
		cfg_addr = REG_B0;
		cfg_data = '0;
		arst_n   = 1'b0;
		filt_coef = '{COEF_ONE, COEF_ZERO, COEF_ZERO, COEF_ZERO, COEF_ZERO};
		filt_hist = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_default_passthrough();
		test_limits_and_rounding();
		test_overflow_history();
		test_coef_extremes();
		test_random_filters(14, 100);

		if (mismatches == 0 && pending_outputs.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
